/* design/tfn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int VTX_W      = 24;  // vertex coordinate, Q12.12
    localparam int DIF_W      = 25;  // edge vector component
    localparam int PRD_W      = 50;  // edge component product
    localparam int CRS_W      = 51;  // signed cross product component
    localparam int MAG_W      = 50;  // cross product magnitude
    localparam int LEN_W      = 6;   // bit length of a magnitude
    localparam int NRM_BITS   = 31;  // width after normalizing shift
    localparam int SQR_W      = 64;  // sum of squares
    localparam int ROOT_W     = 32;  // integer square root
    localparam int SQRT_STEPS = 32;  // one root bit per stage
    localparam int Q_FRAC     = 14;  // Q1.14 fraction bits
    localparam int QUO_W      = 15;  // quotient, at most 16384
    localparam int REM_W      = NRM_BITS + Q_FRAC + 1;
    localparam int OUT_W      = 16;

    typedef logic [2:0][VTX_W-1:0]    vtx_vec_t;
    typedef logic [2:0][MAG_W-1:0]    mag_vec_t;
    typedef logic [2:0][NRM_BITS-1:0] nrm_vec_t;
    typedef logic [2:0][QUO_W-1:0]    quo_vec_t;

    // per-word sideband that rides along the pipeline
    typedef struct packed {
        logic       deg;
        logic       eol;
        logic [2:0] neg;
    } tfn_side_t;

endpackage

/* design/tfn_cross.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, products and cross product magnitudes in three stages.
// ----------------------------------------------------------------------------
module tfn_cross (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  tfn_pkg::vtx_vec_t a,
    input  tfn_pkg::vtx_vec_t b,
    input  tfn_pkg::vtx_vec_t c,
    input  logic             in_eol,
    output logic             out_valid,
    output tfn_pkg::mag_vec_t out_mag,
    output tfn_pkg::tfn_side_t out_side
);
    import tfn_pkg::*;

    logic [2:0]                     valid_reg;
    logic signed [2:0][DIF_W-1:0]   u_reg, v_reg;
    logic signed [5:0][PRD_W-1:0]   p_reg;
    logic signed [2:0][CRS_W-1:0]   w_next;
    logic [2:0]                     eol_reg;
    mag_vec_t                       mag_reg;
    logic [2:0]                     neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_comb begin
        w_next[0] = CRS_W'($signed(p_reg[0])) - CRS_W'($signed(p_reg[1]));
        w_next[1] = CRS_W'($signed(p_reg[2])) - CRS_W'($signed(p_reg[3]));
        w_next[2] = CRS_W'($signed(p_reg[4])) - CRS_W'($signed(p_reg[5]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= DIF_W'($signed(a[i])) - DIF_W'($signed(b[i]));
                v_reg[i] <= DIF_W'($signed(a[i])) - DIF_W'($signed(c[i]));
            end
            p_reg[0] <= PRD_W'($signed(u_reg[1]) * $signed(v_reg[2]));
            p_reg[1] <= PRD_W'($signed(u_reg[2]) * $signed(v_reg[1]));
            p_reg[2] <= PRD_W'($signed(u_reg[2]) * $signed(v_reg[0]));
            p_reg[3] <= PRD_W'($signed(u_reg[0]) * $signed(v_reg[2]));
            p_reg[4] <= PRD_W'($signed(u_reg[0]) * $signed(v_reg[1]));
            p_reg[5] <= PRD_W'($signed(u_reg[1]) * $signed(v_reg[0]));
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= w_next[i][CRS_W-1];
                mag_reg[i] <= w_next[i][CRS_W-1] ? MAG_W'(-w_next[i]) : MAG_W'(w_next[i]);
            end
            eol_reg <= {eol_reg[1:0], in_eol};
        end
    end

    assign out_valid     = valid_reg[2];
    assign out_mag       = mag_reg;
    assign out_side.deg  = 1'b0;
    assign out_side.eol  = eol_reg[2];
    assign out_side.neg  = neg_reg;

endmodule

/* design/tfn_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_norm
// Bit length, normalizing shift, squares and their sum in four stages.
// ----------------------------------------------------------------------------
module tfn_norm (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  tfn_pkg::mag_vec_t         in_mag,
    input  tfn_pkg::tfn_side_t        in_side,
    output logic                      out_valid,
    output tfn_pkg::nrm_vec_t         out_d,
    output logic [tfn_pkg::SQR_W-1:0] out_sum,
    output tfn_pkg::tfn_side_t        out_side
);
    import tfn_pkg::*;

    logic [3:0]                    valid_reg;
    tfn_side_t                     side_reg [4];
    mag_vec_t                      mag_reg;
    logic [LEN_W-1:0]              len_reg;
    logic [LEN_W-1:0]              len_next;
    logic [MAG_W-1:0]              any_mag;
    nrm_vec_t                      d_next;
    nrm_vec_t                      d_reg, d2_reg, d3_reg;
    logic [2:0][2*NRM_BITS-1:0]    sq_reg;
    logic [SQR_W-1:0]              sum_reg;
    logic [MAG_W-1:0]              sh;

    // bit length of the largest magnitude equals that of the or of all
    always_comb begin
        any_mag  = in_mag[0] | in_mag[1] | in_mag[2];
        len_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (any_mag[i]) len_next = LEN_W'(i + 1);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (len_reg > LEN_W'(NRM_BITS)) begin
                sh = mag_reg[i] >> (len_reg - LEN_W'(NRM_BITS));
            end else begin
                sh = mag_reg[i] << (LEN_W'(NRM_BITS) - len_reg);
            end
            d_next[i] = sh[NRM_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg         <= in_mag;
            len_reg         <= len_next;
            side_reg[0]     <= {(any_mag == '0), in_side.eol, in_side.neg};
            d_reg           <= d_next;
            side_reg[1]     <= side_reg[0];
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (2*NRM_BITS)'(d_reg[i]) * (2*NRM_BITS)'(d_reg[i]);
            end
            d2_reg          <= d_reg;
            side_reg[2]     <= side_reg[1];
            sum_reg         <= SQR_W'(sq_reg[0]) + SQR_W'(sq_reg[1]) + SQR_W'(sq_reg[2]);
            d3_reg          <= d2_reg;
            side_reg[3]     <= side_reg[2];
        end
    end

    assign out_valid = valid_reg[3];
    assign out_d     = d3_reg;
    assign out_sum   = sum_reg;
    assign out_side  = side_reg[3];

endmodule

/* design/tfn_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tfn_isqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tfn_pkg::SQR_W-1:0]  in_x,
    input  tfn_pkg::nrm_vec_t          in_d,
    input  tfn_pkg::tfn_side_t         in_side,
    output logic                       out_valid,
    output logic [tfn_pkg::ROOT_W-1:0] out_root,
    output tfn_pkg::nrm_vec_t          out_d,
    output tfn_pkg::tfn_side_t         out_side
);
    import tfn_pkg::*;

    logic [SQRT_STEPS:0]  valid_q;
    logic [SQR_W-1:0]     x_q   [SQRT_STEPS+1];
    logic [SQR_W-1:0]     res_q [SQRT_STEPS+1];
    nrm_vec_t             d_q   [SQRT_STEPS+1];
    tfn_side_t            side_q[SQRT_STEPS+1];

    assign valid_q[0] = in_valid;
    assign x_q[0]     = in_x;
    assign res_q[0]   = '0;
    assign d_q[0]     = in_d;
    assign side_q[0]  = in_side;

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
        localparam logic [SQR_W-1:0] BIT = SQR_W'(1) << (SQR_W - 2 - 2 * j);
        logic [SQR_W-1:0] trial;
        logic [SQR_W-1:0] x_next, res_next;

        always_comb begin
            trial = res_q[j] + BIT;
            if (x_q[j] >= trial) begin
                x_next   = x_q[j] - trial;
                res_next = (res_q[j] >> 1) + BIT;
            end else begin
                x_next   = x_q[j];
                res_next = res_q[j] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_q[j+1] <= 1'b0;
            end else if (en) begin
                valid_q[j+1] <= valid_q[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_q[j+1]    <= x_next;
                res_q[j+1]  <= res_next;
                d_q[j+1]    <= d_q[j];
                side_q[j+1] <= side_q[j];
            end
        end
    end

    assign out_valid = valid_q[SQRT_STEPS];
    assign out_root  = res_q[SQRT_STEPS][ROOT_W-1:0];
    assign out_d     = d_q[SQRT_STEPS];
    assign out_side  = side_q[SQRT_STEPS];

endmodule

/* design/tfn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_div
// Three-lane restoring divider, one quotient bit per stage, rounds half up.
// ----------------------------------------------------------------------------
module tfn_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [tfn_pkg::ROOT_W-1:0] in_root,
    input  tfn_pkg::nrm_vec_t          in_d,
    input  tfn_pkg::tfn_side_t         in_side,
    output logic                       out_valid,
    output tfn_pkg::quo_vec_t          out_q,
    output tfn_pkg::tfn_side_t         out_side
);
    import tfn_pkg::*;

    typedef logic [2:0][REM_W-1:0] rem_vec_t;

    logic [QUO_W:0]     valid_q;
    rem_vec_t           rem_q  [QUO_W+1];
    quo_vec_t           quo_q  [QUO_W+1];
    logic [ROOT_W-1:0]  root_q [QUO_W+1];
    tfn_side_t          side_q [QUO_W+1];
    logic [ROOT_W-1:0]  root_safe;

    // a zero root only comes with a zero product, whose result is forced to zero
    assign root_safe = (in_root == '0) ? ROOT_W'(1) : in_root;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            rem_q[0][l] = {1'b0, in_d[l], Q_FRAC'(0)} + REM_W'(root_safe >> 1);
        end
    end
    assign valid_q[0] = in_valid;
    assign quo_q[0]   = '0;
    assign root_q[0]  = root_safe;
    assign side_q[0]  = in_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [REM_W-1:0] den;
        rem_vec_t         rem_next;
        quo_vec_t         quo_next;

        always_comb begin
            den      = REM_W'(root_q[k]) << SH;
            rem_next = rem_q[k];
            quo_next = quo_q[k];
            for (int l = 0; l < 3; l++) begin
                if (rem_q[k][l] >= den) begin
                    rem_next[l]     = rem_q[k][l] - den;
                    quo_next[l][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_q[k+1] <= 1'b0;
            end else if (en) begin
                valid_q[k+1] <= valid_q[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_q[k+1]  <= rem_next;
                quo_q[k+1]  <= quo_next;
                root_q[k+1] <= root_q[k];
                side_q[k+1] <= side_q[k];
            end
        end
    end

    assign out_valid = valid_q[QUO_W];
    assign out_q     = quo_q[QUO_W];
    assign out_side  = side_q[QUO_W];

endmodule

/* design/triangle_face_normal_unit.sv */
`timescale 1ns / 1ps
// depth: cross, norm, 32-stage root and 15-stage divider, then the output register
// throughput: one triangle per cycle while the output is not stalled
// a stall at the output freezes the whole pipeline, s_axis_tready follows it
// reset empties the pipeline; there is no other state
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Unit face normal of a triangle as a Q1.14 vector, flagging zero area.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [215:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [47:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import tfn_pkg::*;

    logic              en;
    vtx_vec_t          a, b, c;
    logic              cr_valid, nm_valid, sq_valid, dv_valid;
    mag_vec_t          cr_mag;
    tfn_side_t         cr_side, nm_side, sq_side, dv_side;
    nrm_vec_t          nm_d, sq_d;
    logic [SQR_W-1:0]  nm_sum;
    logic [ROOT_W-1:0] sq_root;
    quo_vec_t          dv_q;

    logic              m_valid_reg;
    logic [47:0]       m_data_reg;
    logic              m_deg_reg, m_last_reg;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign a[i] = s_axis_tdata[VTX_W*i +: VTX_W];
        assign b[i] = s_axis_tdata[VTX_W*(i+3) +: VTX_W];
        assign c[i] = s_axis_tdata[VTX_W*(i+6) +: VTX_W];
    end

    tfn_cross u_cross (
        .aclk, .aresetn, .en,
        .in_valid (s_axis_tvalid && s_axis_tready),
        .a, .b, .c,
        .in_eol   (s_axis_tlast),
        .out_valid(cr_valid),
        .out_mag  (cr_mag),
        .out_side (cr_side)
    );

    tfn_norm u_norm (
        .aclk, .aresetn, .en,
        .in_valid (cr_valid),
        .in_mag   (cr_mag),
        .in_side  (cr_side),
        .out_valid(nm_valid),
        .out_d    (nm_d),
        .out_sum  (nm_sum),
        .out_side (nm_side)
    );

    tfn_isqrt u_isqrt (
        .aclk, .aresetn, .en,
        .in_valid (nm_valid),
        .in_x     (nm_sum),
        .in_d     (nm_d),
        .in_side  (nm_side),
        .out_valid(sq_valid),
        .out_root (sq_root),
        .out_d    (sq_d),
        .out_side (sq_side)
    );

    tfn_div u_div (
        .aclk, .aresetn, .en,
        .in_valid (sq_valid),
        .in_root  (sq_root),
        .in_d     (sq_d),
        .in_side  (sq_side),
        .out_valid(dv_valid),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_side.deg) begin
                    m_data_reg[OUT_W*i +: OUT_W] <= '0;
                end else if (dv_side.neg[i]) begin
                    m_data_reg[OUT_W*i +: OUT_W] <= -OUT_W'(dv_q[i]);
                end else begin
                    m_data_reg[OUT_W*i +: OUT_W] <= OUT_W'(dv_q[i]);
                end
            end
            m_deg_reg  <= dv_side.deg;
            m_last_reg <= dv_side.eol;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_deg_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* design/tfn_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_checker
// Port-level checks of the face normal unit, bound to the top level.
// ----------------------------------------------------------------------------
module tfn_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a held result word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a degenerate triangle gives a zero normal
    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 48'd0)
        else $error("degenerate word with nonzero normal");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            $signed(m_axis_tdata[15:0])  <= 16384 && $signed(m_axis_tdata[15:0])  >= -16384 &&
            $signed(m_axis_tdata[31:16]) <= 16384 && $signed(m_axis_tdata[31:16]) >= -16384 &&
            $signed(m_axis_tdata[47:32]) <= 16384 && $signed(m_axis_tdata[47:32]) >= -16384)
        else $error("normal component out of range");

    // an accepting sink never blocks the input
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (
    .aclk, .aresetn, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
    .m_axis_tdata, .m_axis_tuser
);

/* dv/triangle_face_normal_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_unit_tb
// Streams triangles into the face normal unit with random gaps and output
// stalls, predicts each unit normal and compares every result word in order.
// ----------------------------------------------------------------------------
module triangle_face_normal_unit_tb;

    import tfn_pkg::*;

    typedef struct {
        logic [2:0][VTX_W-1:0] a;
        logic [2:0][VTX_W-1:0] b;
        logic [2:0][VTX_W-1:0] c;
        logic                  last;
    } tri_t;

    typedef struct {
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
        logic [OUT_W-1:0] nz;
        logic             deg;
        logic             eol;
    } normal_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         m_axis_tlast;

    tri_t    pending_tris[$];
    normal_t expected_normals[$];
    int      mismatches;
    int      cycle;
    bit      calm;
    bit      stim_done;

    triangle_face_normal_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic normal_t face_normal(tri_t t);
        normal_t         n;
        longint          u[3];
        longint          v[3];
        longint          w[3];
        longint unsigned mag[3];
        bit              neg[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned r;
        longint unsigned q;
        logic [OUT_W-1:0] o[3];
        int              len;
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'($signed(t.a[i])) - longint'($signed(t.b[i]));
            v[i] = longint'($signed(t.a[i])) - longint'($signed(t.c[i]));
        end
        w[0] = u[1] * v[2] - u[2] * v[1];
        w[1] = u[2] * v[0] - u[0] * v[2];
        w[2] = u[0] * v[1] - u[1] * v[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = w[i] < 0;
            mag[i] = neg[i] ? -w[i] : w[i];
            if (mag[i] > m) m = mag[i];
        end
        n.eol = t.last;
        if (m == 0) begin
            n.nx = '0; n.ny = '0; n.nz = '0; n.deg = 1'b1;
            return n;
        end
        len = 0;
        while ((m >> len) != 0) len++;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (len < NRM_BITS) mag[i] <<= (NRM_BITS - len);
            else if (len > NRM_BITS) mag[i] >>= (len - NRM_BITS);
            s += mag[i] * mag[i];
        end
        r = isqrt(s);
        if (r == 0) r = 1;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] * 16384 + (r >> 1)) / r;
            if (q > 16384) q = 16384;
            o[i] = neg[i] ? -q[OUT_W-1:0] : q[OUT_W-1:0];
        end
        n.nx = o[0]; n.ny = o[1]; n.nz = o[2]; n.deg = 1'b0;
        return n;
    endfunction

    function automatic logic [VTX_W-1:0] rand_coord(int shape);
        logic [VTX_W-1:0] c;
        case (shape)
            0: c = VTX_W'($urandom);
            1: c = VTX_W'($urandom_range(0, 8191) - 4096);  // small, near origin
            2: c = ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
            default: c = VTX_W'($urandom_range(0, 16) - 8);
        endcase
        return c;
    endfunction

    task automatic push_tri(tri_t t);
        pending_tris.push_back(t);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_tris.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                tri_t t;
                t = pending_tris.pop_front();
                expected_normals.push_back(face_normal(t));
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {t.c[2], t.c[1], t.c[0], t.b[2], t.b[1], t.b[0],
                                  t.a[2], t.a[1], t.a[0]};
                s_axis_tlast  <= t.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_normals.size() == 0) begin
                    $display("%0t: unexpected word %h user %b last %b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end else begin
                    normal_t e;
                    e = expected_normals.pop_front();
                    if (m_axis_tdata !== {e.nz, e.ny, e.nx} || m_axis_tuser !== e.deg ||
                        m_axis_tlast !== e.eol) begin
                        $display("%0t: expected %h deg %b eol %b, got %h deg %b eol %b",
                                 $time, {e.nz, e.ny, e.nx}, e.deg, e.eol,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        tri_t t;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        mismatches    = 0;
        calm          = 1'b0;
        stim_done     = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: degenerate shapes, extremes, axis-aligned faces
        for (int k = 0; k < 3; k++) begin
            t.a[k] = '0; t.b[k] = '0; t.c[k] = '0;
        end
        t.last = 1'b0;
        push_tri(t);                                    // all points equal
        for (int k = 0; k < 3; k++) begin
            t.a[k] = 24'h7FFFFF; t.b[k] = 24'h800000; t.c[k] = 24'h800000;
        end
        t.last = 1'b1;
        push_tri(t);                                    // coincident b and c
        for (int k = 0; k < 3; k++) begin
            t.a[k] = VTX_W'(k); t.b[k] = VTX_W'(2 * k); t.c[k] = VTX_W'(3 * k);
        end
        push_tri(t);                                    // collinear points
        for (int s = 0; s < 8; s++) begin
            for (int k = 0; k < 3; k++) begin
                t.a[k] = (s[k]) ? 24'h7FFFFF : 24'h800000;
                t.b[k] = (k == 0) ? ~t.a[k] : t.a[k];
                t.c[k] = (k == 1) ? ~t.a[k] : t.a[k];
            end
            t.last = s[0];
            push_tri(t);                                // maximal edges
        end
        for (int ax = 0; ax < 3; ax++) begin
            for (int sg = 0; sg < 2; sg++) begin
                for (int k = 0; k < 3; k++) begin
                    t.a[k] = '0; t.b[k] = '0; t.c[k] = '0;
                end
                t.b[(ax + 1) % 3] = sg ? 24'd1 : -24'sd1;
                t.c[(ax + 2) % 3] = 24'd1;
                t.last = sg[0];
                push_tri(t);                            // tiny unit-axis faces
            end
        end
        t.a[0] = 24'h555555; t.a[1] = 24'hAAAAAA; t.a[2] = 24'h0F0F0F;
        t.b[0] = 24'hAAAAAA; t.b[1] = 24'h555555; t.b[2] = 24'hF0F0F0;
        t.c[0] = 24'h123456; t.c[1] = 24'hEDCBA9; t.c[2] = 24'h000001;
        push_tri(t);

        // random: mix of full range, small, extreme and tiny coordinates
        for (int n = 0; n < 850; n++) begin
            int shape;
            shape = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++) begin
                t.a[k] = rand_coord(shape);
                t.b[k] = rand_coord(shape);
                t.c[k] = rand_coord(shape);
            end
            if ($urandom_range(0, 19) == 0) t.c = t.b;  // occasional zero area
            t.last = $urandom_range(0, 9) == 0;
            push_tri(t);
            if (n == 300) begin
                wait (pending_tris.size() == 0);
                calm = 1'b1;
            end
            if (n == 500) begin
                wait (pending_tris.size() == 0);
                calm = 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    initial begin
        cycle = 0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (stim_done && pending_tris.size() == 0 && !s_axis_tvalid &&
                expected_normals.size() == 0) begin
                repeat (80) @(posedge aclk);
                if (mismatches == 0) begin
                    $display("No mismatches found");
                end else begin
                    $display("Mismatches found");
                end
                $finish;
            end else if (cycle > 200000) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
